/* rtl/led_pixel_buffer_top_macros.svh */
// assertion macros used by the pixel buffer top level
`ifndef LED_PIXEL_BUFFER_TOP_MACROS_SVH
`define LED_PIXEL_BUFFER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel buffer assertion failed");

// next-cycle implication, disabled during reset
`define LPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel buffer assertion failed");

`endif

/* rtl/lpb_pkg.sv */
// types, widths and helpers shared by the pixel buffer modules
package lpb_pkg;

    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 11;
    localparam int COL_W       = 8;
    localparam int ROW_W       = 8;
    localparam int COLOR_W     = 24;
    localparam int COUNT_W     = 11;
    localparam int HEIGHT_W    = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    // col * height + row fits here for every column, row and height
    localparam int ADDR_FULL_W = 15;

    // bit meanings of func
    localparam int FUNC_COLROW_BIT = 0;
    localparam int FUNC_READ_BIT   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_FIRST   = 2'd2;

    typedef struct packed {
        logic                start;
        logic [ROW_W-1:0]    dividend;
        logic [HEIGHT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic                done;
        logic [HEIGHT_W-1:0] rem;
    } mod_rsp_t;

    // exchange the two high bytes of a packed color
    function automatic logic [COLOR_W-1:0] swap_high_bytes(input logic [COLOR_W-1:0] c);
        return {c[15:8], c[23:16], c[7:0]};
    endfunction

endpackage

/* rtl/lpb_ram.sv */
// generic single-port ram with registered read
module lpb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lpb_mod_unit.sv */
// iterative remainder unit, one restoring step per cycle
module lpb_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  lpb_pkg::mod_req_t req,
    output lpb_pkg::mod_rsp_t rsp
);

    localparam int STEP_W = $clog2(lpb_pkg::ROW_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [STEP_W-1:0]            cnt_reg, cnt_next;
    logic [lpb_pkg::ROW_W-1:0]    div_reg, div_next;
    logic [lpb_pkg::HEIGHT_W-1:0] d_reg, d_next;
    logic [lpb_pkg::HEIGHT_W-1:0] rem_reg, rem_next;
    logic [lpb_pkg::HEIGHT_W:0]   trial;

    // partial remainder stays below the divisor, so one more bit fits
    assign trial = {rem_reg, div_reg[lpb_pkg::ROW_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = req.dividend;
            d_next    = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            div_next = {div_reg[lpb_pkg::ROW_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = lpb_pkg::HEIGHT_W'(trial - {1'b0, d_reg});
            end
            else
            begin
                rem_next = lpb_pkg::HEIGHT_W'(trial);
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(lpb_pkg::ROW_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* rtl/led_pixel_buffer_top.sv */
// top level of the led pixel buffer: sequencer, config registers and pixel store
//
// input channel (in_valid / in_stall) takes one command beat: func, pixel_index,
// col_x, row_y, color_in. in_stall is high whenever the sequencer is busy.
// output channel (out_valid / out_stall) gives one beat per read: color_out and
// in_range. writes give no beat.
// config port: cfg_we with cfg_index and cfg_data, written on any edge with
// cfg_we high (0 pixel_count, 1 column_height, 2 green_first).
// the column/row address needs row mod height from the restoring unit,
// one bit per cycle over the 8 row bits; col times height is taken at accept.
// a read result sits in the output register until taken; the next command is
// accepted meanwhile, but its read result waits while out_stall holds.
// after reset the store is cleared one word per cycle, all MAX_PIXELS words, with
// in_stall high; config writes are taken during the clear.
module led_pixel_buffer_top #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lpb_pkg::FUNC_W-1:0]    func,
    input  logic [lpb_pkg::IDX_W-1:0]     pixel_index,
    input  logic [lpb_pkg::COL_W-1:0]     col_x,
    input  logic [lpb_pkg::ROW_W-1:0]     row_y,
    input  logic [lpb_pkg::COLOR_W-1:0]   color_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lpb_pkg::COLOR_W-1:0]   color_out,
    output logic                          in_range,
    input  logic                          cfg_we,
    input  logic [lpb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpb_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "led_pixel_buffer_top_macros.svh"

    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam logic [lpb_pkg::ADDR_FULL_W-1:0] MAX_LIMIT =
        lpb_pkg::ADDR_FULL_W'(MAX_PIXELS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_READ
    } state_t;

    state_t                          state_reg, state_next;
    logic [ADDR_W-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [lpb_pkg::COUNT_W-1:0]     pixel_count_reg, pixel_count_next;
    logic [lpb_pkg::HEIGHT_W-1:0]    column_height_reg, column_height_next;
    logic                            green_first_reg, green_first_next;
    logic [lpb_pkg::FUNC_W-1:0]      func_reg, func_next;
    logic [lpb_pkg::COLOR_W-1:0]     color_reg, color_next;
    logic [lpb_pkg::ADDR_FULL_W-1:0] prod_reg, prod_next;
    logic [lpb_pkg::ADDR_FULL_W-1:0] addr_reg, addr_next;
    logic                            ok_reg, ok_next;
    logic                            out_valid_reg, out_valid_next;
    logic [lpb_pkg::COLOR_W-1:0]     color_out_reg, color_out_next;
    logic                            in_range_reg, in_range_next;

    logic [lpb_pkg::HEIGHT_W-1:0]    h_eff;
    logic [lpb_pkg::ADDR_FULL_W-1:0] count_ext;
    logic [lpb_pkg::ADDR_FULL_W-1:0] limit;
    logic                            ok_c;
    logic                            accept;
    logic                            ram_we;
    logic                            ram_re;
    logic [ADDR_W-1:0]               ram_addr;
    logic [lpb_pkg::COLOR_W-1:0]     ram_wdata;
    logic [lpb_pkg::COLOR_W-1:0]     ram_rdata;
    lpb_pkg::mod_req_t               mod_req;
    lpb_pkg::mod_rsp_t               mod_rsp;

    // a height of zero acts as one
    assign h_eff     = (column_height_reg == '0) ? lpb_pkg::HEIGHT_W'(1) : column_height_reg;
    assign count_ext = lpb_pkg::ADDR_FULL_W'(pixel_count_reg);
    assign limit     = (count_ext > MAX_LIMIT) ? MAX_LIMIT : count_ext;
    assign ok_c      = addr_reg < limit;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    assign mod_req.start    = accept && func[lpb_pkg::FUNC_COLROW_BIT];
    assign mod_req.dividend = row_y;
    assign mod_req.divisor  = h_eff;

    lpb_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = addr_reg[ADDR_W-1:0];
        ram_wdata = green_first_reg ? lpb_pkg::swap_high_bytes(color_reg) : color_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_CHECK:
            begin
                ram_we = ok_c && !func_reg[lpb_pkg::FUNC_READ_BIT];
                ram_re = ok_c && func_reg[lpb_pkg::FUNC_READ_BIT];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    lpb_ram #(
        .WIDTH (lpb_pkg::COLOR_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next         = state_reg;
        clr_cnt_next       = clr_cnt_reg;
        pixel_count_next   = pixel_count_reg;
        column_height_next = column_height_reg;
        green_first_next   = green_first_reg;
        func_next          = func_reg;
        color_next         = color_reg;
        prod_next          = prod_reg;
        addr_next          = addr_reg;
        ok_next            = ok_reg;
        out_valid_next     = out_valid_reg;
        color_out_next     = color_out_reg;
        in_range_next      = in_range_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                lpb_pkg::CFG_PIXEL_COUNT:   pixel_count_next   = cfg_data;
                lpb_pkg::CFG_COLUMN_HEIGHT: column_height_next = cfg_data[lpb_pkg::HEIGHT_W-1:0];
                lpb_pkg::CFG_GREEN_FIRST:   green_first_next   = cfg_data[0];
                default:                    pixel_count_next   = pixel_count_reg;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MAX_PIXELS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    color_next = color_in;
                    prod_next  = lpb_pkg::ADDR_FULL_W'(col_x) * lpb_pkg::ADDR_FULL_W'(h_eff);
                    addr_next  = lpb_pkg::ADDR_FULL_W'(pixel_index);
                    if (func[lpb_pkg::FUNC_COLROW_BIT])
                    begin
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_rsp.done)
                begin
                    addr_next  = prod_reg + lpb_pkg::ADDR_FULL_W'(mod_rsp.rem);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                ok_next = ok_c;
                if (func_reg[lpb_pkg::FUNC_READ_BIT])
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                // hold the read data until the output register is free
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    in_range_next  = ok_reg;
                    if (ok_reg)
                    begin
                        color_out_next = green_first_reg ?
                            lpb_pkg::swap_high_bytes(ram_rdata) : ram_rdata;
                    end
                    else
                    begin
                        color_out_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            pixel_count_reg   <= '0;
            column_height_reg <= lpb_pkg::HEIGHT_W'(1);
            green_first_reg   <= 1'b0;
            func_reg          <= '0;
            color_reg         <= '0;
            prod_reg          <= '0;
            addr_reg          <= '0;
            ok_reg            <= 1'b0;
            out_valid_reg     <= 1'b0;
            color_out_reg     <= '0;
            in_range_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_cnt_reg       <= clr_cnt_next;
            pixel_count_reg   <= pixel_count_next;
            column_height_reg <= column_height_next;
            green_first_reg   <= green_first_next;
            func_reg          <= func_next;
            color_reg         <= color_next;
            prod_reg          <= prod_next;
            addr_reg          <= addr_next;
            ok_reg            <= ok_next;
            out_valid_reg     <= out_valid_next;
            color_out_reg     <= color_out_next;
            in_range_reg      <= in_range_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign color_out = color_out_reg;
    assign in_range  = in_range_reg;

    `LPB_ASSERT_IMP(a_clear_writes_zero, clk, rst_n,
        state_reg == ST_CLEAR, ram_we && ram_wdata == '0)
    `LPB_ASSERT_IMP(a_write_in_range, clk, rst_n,
        ram_we && state_reg == ST_CHECK, addr_reg < limit)
    `LPB_ASSERT_IMP(a_miss_reads_zero, clk, rst_n,
        out_valid_reg && !in_range_reg, color_out_reg == '0)
    `LPB_ASSERT_IMP(a_rem_below_height, clk, rst_n,
        mod_rsp.done, mod_rsp.rem < h_eff)
    `LPB_ASSERT_NXT(a_mod_done_to_check, clk, rst_n,
        state_reg == ST_MOD && mod_rsp.done, state_reg == ST_CHECK)

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the led pixel buffer: directed and random reads and writes against a shadow store
module tb;

    localparam int STORE_DEPTH = 1024;
    localparam int IDLE_SETTLE = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES  = 8;

    localparam logic [lpb_pkg::FUNC_W-1:0] OP_WRITE_IDX = 2'd0;
    localparam logic [lpb_pkg::FUNC_W-1:0] OP_WRITE_CR  = 2'd1;
    localparam logic [lpb_pkg::FUNC_W-1:0] OP_READ_IDX  = 2'd2;
    localparam logic [lpb_pkg::FUNC_W-1:0] OP_READ_CR   = 2'd3;

    typedef struct packed {
        logic [lpb_pkg::FUNC_W-1:0]  op;
        logic [lpb_pkg::IDX_W-1:0]   idx;
        logic [lpb_pkg::COL_W-1:0]   col;
        logic [lpb_pkg::ROW_W-1:0]   row;
        logic [lpb_pkg::COLOR_W-1:0] color;
    } pixel_cmd_t;

    typedef struct packed {
        logic [lpb_pkg::COLOR_W-1:0] color;
        logic                        hit;
    } readback_t;

    class pixel_scoreboard;
        logic [lpb_pkg::COLOR_W-1:0]  shadow [STORE_DEPTH];
        logic [lpb_pkg::COUNT_W-1:0]  count_reg;
        logic [lpb_pkg::HEIGHT_W-1:0] height_reg;
        logic                         green_reg;
        readback_t                    expected_reads [$];
        int                           errors;

        function new();
            foreach (shadow[i])
                shadow[i] = '0;
            count_reg  = '0;
            height_reg = 7'd1;
            green_reg  = 1'b0;
            errors     = 0;
        endfunction

        function int unsigned height_used();
            return (height_reg == 0) ? 32'd1 : 32'(height_reg);
        endfunction

        function int unsigned pixels_in_use();
            return (32'(count_reg) > STORE_DEPTH) ? 32'(STORE_DEPTH) : 32'(count_reg);
        endfunction

        // exchanges red and green bytes, used both to store and to decode
        function logic [lpb_pkg::COLOR_W-1:0] rg_swap(logic [lpb_pkg::COLOR_W-1:0] c);
            return {c[15:8], c[23:16], c[7:0]};
        endfunction

        function void set_reg(logic [lpb_pkg::CFG_IDX_W-1:0] index, int unsigned data);
            case (index)
                lpb_pkg::CFG_PIXEL_COUNT:   count_reg = data[lpb_pkg::COUNT_W-1:0];
                lpb_pkg::CFG_COLUMN_HEIGHT: height_reg = data[lpb_pkg::HEIGHT_W-1:0];
                lpb_pkg::CFG_GREEN_FIRST:   green_reg = data[0];
                default: ;
            endcase
        endfunction

        function void note_command(pixel_cmd_t c);
            int unsigned addr;
            readback_t   r;
            if (c.op[lpb_pkg::FUNC_COLROW_BIT])
                addr = 32'(c.row) % height_used() + 32'(c.col) * height_used();
            else
                addr = 32'(c.idx);
            if (!c.op[lpb_pkg::FUNC_READ_BIT])
            begin
                if (addr < pixels_in_use())
                    shadow[addr] = green_reg ? rg_swap(c.color) : c.color;
            end
            else
            begin
                if (addr < pixels_in_use())
                begin
                    r.color = green_reg ? rg_swap(shadow[addr]) : shadow[addr];
                    r.hit   = 1'b1;
                end
                else
                begin
                    r.color = '0;
                    r.hit   = 1'b0;
                end
                expected_reads.push_back(r);
            end
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10)
                $display("%s", what);
        endfunction

        function void check_readback(logic [lpb_pkg::COLOR_W-1:0] color, logic hit);
            readback_t e;
            if (expected_reads.size() == 0)
            begin
                report($sformatf("readback with none pending: color %06h in_range %0b",
                                 color, hit));
                return;
            end
            e = expected_reads.pop_front();
            if (color !== e.color || hit !== e.hit)
                report($sformatf("readback mismatch: expected %06h/%0b, got %06h/%0b",
                                 e.color, e.hit, color, hit));
        endfunction

        function int unsigned pending();
            return expected_reads.size();
        endfunction

        function int final_errors();
            if (expected_reads.size() != 0)
                report($sformatf("%0d readbacks never arrived", expected_reads.size()));
            return errors;
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [lpb_pkg::FUNC_W-1:0]     func;
    logic [lpb_pkg::IDX_W-1:0]      pixel_index;
    logic [lpb_pkg::COL_W-1:0]      col_x;
    logic [lpb_pkg::ROW_W-1:0]      row_y;
    logic [lpb_pkg::COLOR_W-1:0]    color_in;
    logic                           out_valid;
    logic                           out_stall;
    logic [lpb_pkg::COLOR_W-1:0]    color_out;
    logic                           in_range;
    logic                           cfg_we;
    logic [lpb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lpb_pkg::CFG_DATA_W-1:0] cfg_data;

    pixel_scoreboard sb;
    bit              hold_req = 1'b0;
    int unsigned     recent_addrs [$];

    led_pixel_buffer_top #(
        .MAX_PIXELS(STORE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .pixel_index(pixel_index),
        .col_x(col_x),
        .row_y(row_y),
        .color_in(color_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .color_out(color_out),
        .in_range(in_range),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic pixel_cmd_t make_cmd(logic [lpb_pkg::FUNC_W-1:0] op, int unsigned idx,
                                            int unsigned col, int unsigned row,
                                            logic [lpb_pkg::COLOR_W-1:0] color);
        pixel_cmd_t c;
        c.op    = op;
        c.idx   = idx[lpb_pkg::IDX_W-1:0];
        c.col   = col[lpb_pkg::COL_W-1:0];
        c.row   = row[lpb_pkg::ROW_W-1:0];
        c.color = color;
        return c;
    endfunction

    // mostly aimed at live pixels, recently written ones preferred; the rest is raw noise
    function automatic pixel_cmd_t random_cmd();
        pixel_cmd_t  c;
        int unsigned lim;
        int unsigned h;
        int unsigned a;
        c = make_cmd(lpb_pkg::FUNC_W'($urandom_range(OP_WRITE_IDX, OP_READ_CR)), $urandom,
                     $urandom, $urandom, lpb_pkg::COLOR_W'($urandom));
        lim = sb.pixels_in_use();
        h   = sb.height_used();
        if (lim > 0 && $urandom_range(0, 3) != 0)
        begin
            if (recent_addrs.size() > 0 && $urandom_range(0, 1) == 1)
                a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
            else
                a = $urandom_range(0, lim - 1);
            if (!c.op[lpb_pkg::FUNC_READ_BIT])
            begin
                recent_addrs.push_back(a);
                if (recent_addrs.size() > 16)
                    void'(recent_addrs.pop_front());
            end
            c.idx = a[lpb_pkg::IDX_W-1:0];
            if (c.op[lpb_pkg::FUNC_COLROW_BIT])
            begin
                if (a / h > 255)
                    c.op[lpb_pkg::FUNC_COLROW_BIT] = 1'b0;
                else
                begin
                    // add whole columns to the row so the modulo has work to do
                    c.col = lpb_pkg::COL_W'(a / h);
                    c.row = lpb_pkg::ROW_W'(a % h + h * $urandom_range(0, (255 - a % h) / h));
                end
            end
        end
        return c;
    endfunction

    // leaves in_valid high after the accepting edge; caller sends again or lowers it
    task automatic send_beat(input pixel_cmd_t c);
        in_valid    <= 1'b1;
        func        <= c.op;
        pixel_index <= c.idx;
        col_x       <= c.col;
        row_y       <= c.row;
        color_in    <= c.color;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(c);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // a trailing write may still be in flight with nothing pending
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lpb_pkg::CFG_IDX_W-1:0] index,
                             input int unsigned data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data[lpb_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        sb.set_reg(index, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // result side: stall pattern of its own plus one long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_readback(color_out, in_range);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
        end
    end

    initial
    begin : stimulus
        int unsigned ph_count  [NUM_PHASES] = '{1024, 16, 2047, 1024, 0, 300, 1, 1023};
        int unsigned ph_height [NUM_PHASES] = '{8, 1, 0, 127, 64, 5, 3, 4};
        int unsigned ph_green  [NUM_PHASES] = '{0, 1, 0, 1, 0, 0, 1, 0};
        int unsigned ph_items  [NUM_PHASES] = '{260, 220, 220, 220, 60, 260, 160, 300};
        int          n;
        int          k;
        int          burst;
        int          gap;
        sb = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= OP_WRITE_IDX;
        pixel_index <= '0;
        col_x       <= '0;
        row_y       <= '0;
        color_in    <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= lpb_pkg::CFG_PIXEL_COUNT;
        cfg_data    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: nothing is in range yet
        send_beat(make_cmd(OP_READ_IDX, 0, 0, 0, 24'h000000));
        send_beat(make_cmd(OP_WRITE_IDX, 0, 0, 0, 24'hFFFFFF));
        send_beat(make_cmd(OP_READ_CR, 0, 0, 0, 24'h000000));

        // count above capacity, zero height
        wait_idle();
        write_reg(lpb_pkg::CFG_PIXEL_COUNT, 2047);
        write_reg(lpb_pkg::CFG_COLUMN_HEIGHT, 0);
        send_beat(make_cmd(OP_WRITE_IDX, 0, 0, 0, 24'hFFFFFF));
        send_beat(make_cmd(OP_WRITE_IDX, 1023, 0, 0, 24'h123456));
        send_beat(make_cmd(OP_WRITE_IDX, 1024, 0, 0, 24'hABCDEF));
        send_beat(make_cmd(OP_WRITE_IDX, 2047, 0, 0, 24'h0F0F0F));
        send_beat(make_cmd(OP_READ_IDX, 0, 0, 0, 24'h000000));
        send_beat(make_cmd(OP_READ_IDX, 1023, 0, 0, 24'h000000));
        send_beat(make_cmd(OP_READ_IDX, 1024, 0, 0, 24'h000000));
        send_beat(make_cmd(OP_READ_IDX, 2047, 0, 0, 24'h000000));
        send_beat(make_cmd(OP_WRITE_CR, 0, 255, 255, 24'hA5A5A5));
        send_beat(make_cmd(OP_READ_CR, 0, 255, 0, 24'h000000));
        send_beat(make_cmd(OP_READ_IDX, 255, 0, 0, 24'h000000));

        // byte order flips over stored data
        wait_idle();
        write_reg(lpb_pkg::CFG_GREEN_FIRST, 1);
        send_beat(make_cmd(OP_READ_IDX, 1023, 0, 0, 24'h000000));
        send_beat(make_cmd(OP_WRITE_IDX, 5, 0, 0, 24'h112233));
        send_beat(make_cmd(OP_READ_IDX, 5, 0, 0, 24'h000000));

        // shrinking the count keeps the store, tallest column
        wait_idle();
        write_reg(lpb_pkg::CFG_PIXEL_COUNT, 6);
        write_reg(lpb_pkg::CFG_COLUMN_HEIGHT, 127);
        send_beat(make_cmd(OP_READ_CR, 0, 0, 5, 24'h000000));
        send_beat(make_cmd(OP_READ_CR, 0, 255, 255, 24'h000000));
        send_beat(make_cmd(OP_WRITE_CR, 0, 0, 132, 24'h00FF00));
        send_beat(make_cmd(OP_READ_IDX, 5, 0, 0, 24'h000000));
        wait_idle();
        write_reg(lpb_pkg::CFG_GREEN_FIRST, 0);
        send_beat(make_cmd(OP_READ_IDX, 5, 0, 0, 24'h000000));

        ph_count[5]  = $urandom_range(100, 1000);
        ph_height[5] = $urandom_range(1, 64);
        ph_green[5]  = $urandom_range(0, 1);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_reg(lpb_pkg::CFG_PIXEL_COUNT, ph_count[p]);
            write_reg(lpb_pkg::CFG_COLUMN_HEIGHT, ph_height[p]);
            write_reg(lpb_pkg::CFG_GREEN_FIRST, ph_green[p]);
            n = 0;
            while (n < ph_items[p])
            begin
                burst = $urandom_range(1, 24);
                for (k = 0; k < burst && n < ph_items[p]; k++)
                begin
                    send_beat(random_cmd());
                    n++;
                    // long output hold-off while beats keep coming
                    if (p == 0 && n == 80)
                        hold_req = 1'b1;
                    if (p == 1 && n == 110)
                        wait_idle();
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        wait_idle();

        if (sb.final_errors() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
